[hdl/rsae_pkg.sv]
// ----------------------------------------------------------------------------
// rsae_pkg - shared types and constants for the status animation engine
// Microcode word layout, program addresses, status codes, register indexes
// and reset values.
// ----------------------------------------------------------------------------
package rsae_pkg;

  // Status codes
  localparam logic [3:0] ST_HEARTBEAT = 4'd1;
  localparam logic [3:0] ST_BREATHE   = 4'd2;
  localparam logic [3:0] ST_SPARKLE   = 4'd4;
  localparam logic [3:0] ST_BLEND     = 4'd15;

  // Phase increments per frame
  localparam logic [15:0] STEP_HEARTBEAT = 16'd875;
  localparam logic [15:0] STEP_BREATHE   = 16'd655;
  localparam logic [15:0] STEP_SPARKLE   = 16'd1;
  localparam logic [15:0] STEP_BLEND     = 16'd400;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HEARTBEAT   = 3'd0,
    REG_BREATHE     = 3'd1,
    REG_SPARKLE     = 3'd2,
    REG_BLEND_START = 3'd3,
    REG_BLEND_END   = 3'd4,
    REG_PEAK        = 3'd5
  } cfg_reg_t;

  localparam logic [23:0] RST_HEARTBEAT   = 24'hFF0000;
  localparam logic [23:0] RST_BREATHE     = 24'hFFFF00;
  localparam logic [23:0] RST_SPARKLE     = 24'h800080;
  localparam logic [23:0] RST_BLEND_START = 24'h0000FF;
  localparam logic [23:0] RST_BLEND_END   = 24'h00FFFF;
  localparam logic [7:0]  RST_PEAK        = 8'd128;

  localparam logic [6:0]  CHANCE_BRIGHT   = 7'd15;
  localparam logic [7:0]  K_FULL          = 8'd255;
  localparam logic [7:0]  K_THIRD         = 8'd171; // x/3 == (x*171)>>9 for 8-bit x

  // Microcode fields
  typedef enum logic [3:0] {
    OP_NOP, OP_DISPATCH, OP_MUL_ACC, OP_MUL_HB, OP_MUL_CH,
    OP_LERP, OP_SPK_MAX, OP_SPK_GLOW, OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    A_TRI, A_POS, A_ACC, A_PEAK, A_DIFF, A_CH, A_COL
  } a_sel_t;

  typedef enum logic [1:0] {
    B_K255, B_K171, B_ACC, B_PEAK
  } b_sel_t;

  typedef enum logic [1:0] {
    POST_DIV255, POST_SHR15, POST_SHR13, POST_SHR9
  } post_t;

  typedef enum logic [1:0] {
    COND_NEXT, COND_JUMP, COND_GLOW
  } cond_t;

  typedef logic [4:0] pc_t;

  typedef struct packed {
    op_t        op;
    a_sel_t     a;
    b_sel_t     b;
    post_t      post;
    logic [1:0] k;       // color lane: 0 red, 1 green, 2 blue
    cond_t      cond;
    pc_t        target;
    logic       last;
  } uword_t;

  // Program entry points
  localparam pc_t PC_DISPATCH = 5'd0;
  localparam pc_t PC_HB       = 5'd1;
  localparam pc_t PC_BR       = 5'd3;
  localparam pc_t PC_SP       = 5'd6;
  localparam pc_t PC_SP_GLOW  = 5'd9;
  localparam pc_t PC_BL       = 5'd10;
  localparam pc_t PC_BLACK    = 5'd17;
  localparam pc_t PC_TAIL     = 5'd18;
  localparam pc_t PC_END      = 5'd20;

  function automatic uword_t uw(op_t op, a_sel_t a, b_sel_t b, post_t post,
                                logic [1:0] k, cond_t cond, pc_t target,
                                logic last);
    uword_t w;
    w.op     = op;
    w.a      = a;
    w.b      = b;
    w.post   = post;
    w.k      = k;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // Control store
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      5'd0:  w = uw(OP_DISPATCH, A_ACC, B_K255, POST_DIV255, 2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      // heartbeat
      5'd1:  w = uw(OP_MUL_HB,  A_POS,  B_K255, POST_SHR13,  2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd2:  w = uw(OP_MUL_ACC, A_ACC,  B_PEAK, POST_DIV255, 2'd0, COND_JUMP, PC_TAIL, 1'b0);
      // breathe
      5'd3:  w = uw(OP_MUL_ACC, A_TRI,  B_K255, POST_SHR15,  2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd4:  w = uw(OP_MUL_ACC, A_ACC,  B_ACC,  POST_DIV255, 2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd5:  w = uw(OP_MUL_ACC, A_ACC,  B_PEAK, POST_DIV255, 2'd0, COND_JUMP, PC_TAIL, 1'b0);
      // sparkle
      5'd6:  w = uw(OP_MUL_ACC, A_PEAK, B_K171, POST_SHR9,   2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd7:  w = uw(OP_NOP,     A_ACC,  B_K255, POST_DIV255, 2'd0, COND_GLOW, PC_SP_GLOW, 1'b0);
      5'd8:  w = uw(OP_SPK_MAX, A_ACC,  B_K255, POST_DIV255, 2'd0, COND_JUMP, PC_TAIL, 1'b0);
      5'd9:  w = uw(OP_SPK_GLOW, A_ACC, B_K255, POST_DIV255, 2'd0, COND_JUMP, PC_TAIL, 1'b0);
      // blend
      5'd10: w = uw(OP_MUL_ACC, A_TRI,  B_K255, POST_SHR15,  2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd11: w = uw(OP_LERP,    A_DIFF, B_ACC,  POST_DIV255, 2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd12: w = uw(OP_LERP,    A_DIFF, B_ACC,  POST_DIV255, 2'd1, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd13: w = uw(OP_LERP,    A_DIFF, B_ACC,  POST_DIV255, 2'd2, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd14: w = uw(OP_MUL_CH,  A_CH,   B_PEAK, POST_DIV255, 2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd15: w = uw(OP_MUL_CH,  A_CH,   B_PEAK, POST_DIV255, 2'd1, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd16: w = uw(OP_MUL_CH,  A_CH,   B_PEAK, POST_DIV255, 2'd2, COND_NEXT, PC_DISPATCH, 1'b1);
      // black
      5'd17: w = uw(OP_CLEAR,   A_ACC,  B_K255, POST_DIV255, 2'd0, COND_NEXT, PC_DISPATCH, 1'b1);
      // common tail: color lane times brightness
      5'd18: w = uw(OP_MUL_CH,  A_COL,  B_ACC,  POST_DIV255, 2'd0, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd19: w = uw(OP_MUL_CH,  A_COL,  B_ACC,  POST_DIV255, 2'd1, COND_NEXT, PC_DISPATCH, 1'b0);
      5'd20: w = uw(OP_MUL_CH,  A_COL,  B_ACC,  POST_DIV255, 2'd2, COND_NEXT, PC_DISPATCH, 1'b1);
      default: w = uw(OP_CLEAR, A_ACC,  B_K255, POST_DIV255, 2'd0, COND_NEXT, PC_DISPATCH, 1'b1);
    endcase
    return w;
  endfunction

  function automatic pc_t entry_of(logic [3:0] status);
    pc_t pc;
    case (status)
      ST_HEARTBEAT: pc = PC_HB;
      ST_BREATHE:   pc = PC_BR;
      ST_SPARKLE:   pc = PC_SP;
      ST_BLEND:     pc = PC_BL;
      default:      pc = PC_BLACK;
    endcase
    return pc;
  endfunction

  function automatic logic [15:0] phase_step(logic [3:0] status);
    logic [15:0] s;
    case (status)
      ST_HEARTBEAT: s = STEP_HEARTBEAT;
      ST_BREATHE:   s = STEP_BREATHE;
      ST_SPARKLE:   s = STEP_SPARKLE;
      ST_BLEND:     s = STEP_BLEND;
      default:      s = 16'd0;
    endcase
    return s;
  endfunction

  // Lane of a packed RRGGBB word
  function automatic logic [7:0] chan_of(logic [23:0] rgb, logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = rgb[23:16];
      2'd1:    c = rgb[15:8];
      2'd2:    c = rgb[7:0];
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] set_chan(logic [23:0] rgb, logic [1:0] k,
                                           logic [7:0] c);
    logic [23:0] r;
    r = rgb;
    case (k)
      2'd0:    r[23:16] = c;
      2'd1:    r[15:8]  = c;
      2'd2:    r[7:0]   = c;
      default: r = rgb;
    endcase
    return r;
  endfunction

endpackage

[hdl/rsae_if.sv]
// ----------------------------------------------------------------------------
// rsae_if - request channels of the status animation engine
// Frame request in, RGB level request out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsae_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] status_code;
  logic [7:0] spark_draw;
  logic [6:0] chance_draw;
  logic [5:0] glow_draw;

  modport source (output valid, status_code, spark_draw, chance_draw, glow_draw,
                  input ready);
  modport sink   (input valid, status_code, spark_draw, chance_draw, glow_draw,
                  output ready);
endinterface

interface rsae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface

[hdl/rgb_status_animation_engine_unit.sv]
// ----------------------------------------------------------------------------
// rgb_status_animation_engine_unit - status LED animation frame generator
// Microcoded engine that turns one frame request into one RGB color.
// ----------------------------------------------------------------------------
// One frame request in, one RGB request out. Status 1 is a double-beat
// heartbeat, 2 a squared-triangle breathing curve, 4 a sparkle over a dim
// glow, 15 a triangle blend between two colors; any other code gives black.
// A 16-bit phase advances by a per-status step at the start of each frame.
// The work runs as a short microprogram over one shared 15x8 multiplier with
// a divide-by-255 and shift stage behind it; the multiplier does one product
// per program step. The next request is taken the cycle after the final step.
// The finished color sits in an output register, so a new request is taken
// while the previous color waits; the final step stalls only if that
// register is still full. Configuration writes (cfg_we, cfg_idx, cfg_data)
// are for the user to make only while idle; the block itself does not
// enforce this. Indexes 6 and 7 are ignored.
// ----------------------------------------------------------------------------
module rgb_status_animation_engine_unit (
  input  logic          clk,
  input  logic          rst_n,
  rsae_in_if.sink       in_ch,
  rsae_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [23:0]   cfg_data
);
  import rsae_pkg::*;

  // config registers
  logic [23:0] hb_col_r, br_col_r, sp_col_r, bl_start_r, bl_end_r;
  logic [7:0]  peak_r;

  // request latch
  logic [3:0] status_r;
  logic [7:0] spark_r;
  logic [6:0] chance_r;
  logic [5:0] glow_r;

  // sequencer and datapath
  logic        busy_r, busy_nxt;
  pc_t         pc_r, pc_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [23:0] col_r, col_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [23:0] ch_r, ch_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] red_r, green_r, blue_r;

  uword_t      uw_c;
  logic        hold, step_en, in_fire;
  logic [14:0] tri_m, opa;
  logic [7:0]  opb;
  logic [22:0] prod;
  logic [16:0] dsum;
  logic [7:0]  res8, hb8;
  logic [7:0]  bs, be, diff, smax;
  logic [8:0]  gsum;
  logic [2:0]  seg;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !busy_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.red_level   = red_r;
  assign out_ch.green_level = green_r;
  assign out_ch.blue_level  = blue_r;

  // --- configuration ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_col_r   <= RST_HEARTBEAT;
      br_col_r   <= RST_BREATHE;
      sp_col_r   <= RST_SPARKLE;
      bl_start_r <= RST_BLEND_START;
      bl_end_r   <= RST_BLEND_END;
      peak_r     <= RST_PEAK;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HEARTBEAT:   hb_col_r   <= cfg_data;
        REG_BREATHE:     br_col_r   <= cfg_data;
        REG_SPARKLE:     sp_col_r   <= cfg_data;
        REG_BLEND_START: bl_start_r <= cfg_data;
        REG_BLEND_END:   bl_end_r   <= cfg_data;
        REG_PEAK:        peak_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // --- request latch (payload, no reset) ---
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= in_ch.status_code;
      spark_r  <= in_ch.spark_draw;
      chance_r <= in_ch.chance_draw;
      glow_r   <= in_ch.glow_draw;
    end
  end

  // --- datapath and sequencer ---
  always_comb begin
    uw_c    = ucode(pc_r);
    // final step waits while the previous color is still unclaimed
    hold    = uw_c.last && out_valid_r && !out_ch.ready;
    step_en = busy_r && !hold;

    // triangle: folded phase, 0..32767
    tri_m = phase_r[15] ? ~phase_r[14:0] : phase_r[14:0];

    bs   = chan_of(bl_start_r, uw_c.k);
    be   = chan_of(bl_end_r, uw_c.k);
    diff = (be >= bs) ? (be - bs) : (bs - be);

    case (uw_c.a)
      A_TRI:   opa = tri_m;
      A_POS:   opa = {2'b00, phase_r[12:0]};
      A_ACC:   opa = {7'd0, acc_r};
      A_PEAK:  opa = {7'd0, peak_r};
      A_DIFF:  opa = {7'd0, diff};
      A_CH:    opa = {7'd0, chan_of(ch_r, uw_c.k)};
      A_COL:   opa = {7'd0, chan_of(col_r, uw_c.k)};
      default: opa = 15'd0;
    endcase

    case (uw_c.b)
      B_K255:  opb = K_FULL;
      B_K171:  opb = K_THIRD;
      B_ACC:   opb = acc_r;
      B_PEAK:  opb = peak_r;
      default: opb = 8'd0;
    endcase

    prod = 23'(opa) * 23'(opb);

    // x/255 for x <= 255*255: (x + (x>>8) + 1) >> 8
    dsum = 17'(prod[15:0]) + 17'(prod[15:8]) + 17'd1;

    case (uw_c.post)
      POST_DIV255: res8 = dsum[15:8];
      POST_SHR15:  res8 = prod[22:15];
      POST_SHR13:  res8 = prod[20:13];
      POST_SHR9:   res8 = prod[16:9];
      default:     res8 = 8'd0;
    endcase

    // heartbeat segments: rise, fall, rise, fall, then rest
    seg = phase_r[15:13];
    case (seg)
      3'd0, 3'd2: hb8 = res8;
      3'd1, 3'd3: hb8 = K_FULL - res8;
      default:    hb8 = 8'd0;
    endcase

    smax = (spark_r > acc_r) ? spark_r : acc_r;
    gsum = {1'b0, acc_r} + 9'(glow_r);

    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    phase_nxt     = phase_r;
    col_nxt       = col_r;
    acc_nxt       = acc_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (in_fire) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_DISPATCH;
    end else if (step_en) begin
      case (uw_c.op)
        OP_DISPATCH: begin
          phase_nxt = phase_r + phase_step(status_r);
          case (status_r)
            ST_HEARTBEAT: col_nxt = hb_col_r;
            ST_BREATHE:   col_nxt = br_col_r;
            ST_SPARKLE:   col_nxt = sp_col_r;
            default:      col_nxt = col_r;
          endcase
        end
        OP_MUL_ACC:  acc_nxt = res8;
        OP_MUL_HB:   acc_nxt = hb8;
        OP_MUL_CH:   ch_nxt  = set_chan(ch_r, uw_c.k, res8);
        OP_LERP:     ch_nxt  = set_chan(ch_r, uw_c.k,
                                        (be >= bs) ? (bs + res8) : (bs - res8));
        OP_SPK_MAX:  acc_nxt = (smax > peak_r) ? peak_r : smax;
        OP_SPK_GLOW: acc_nxt = (gsum > {1'b0, peak_r}) ? peak_r : gsum[7:0];
        OP_CLEAR:    ch_nxt  = 24'd0;
        default: ;
      endcase

      if (uw_c.op == OP_DISPATCH) begin
        pc_nxt = entry_of(status_r);
      end else begin
        case (uw_c.cond)
          COND_JUMP: pc_nxt = uw_c.target;
          COND_GLOW: pc_nxt = (chance_r >= CHANCE_BRIGHT) ? uw_c.target : pc_r + 5'd1;
          default:   pc_nxt = pc_r + 5'd1;
        endcase
      end

      if (uw_c.last) begin
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_DISPATCH;
      phase_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    acc_r <= acc_nxt;
    ch_r  <= ch_nxt;
    if (step_en && uw_c.last) begin
      red_r   <= ch_nxt[23:16];
      green_r <= ch_nxt[15:8];
      blue_r  <= ch_nxt[7:0];
    end
  end

  // --- checks ---
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy_r && pc_r == PC_DISPATCH)
    else $error("accepted request did not start at dispatch");

  a_phase_once: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && pc_r != PC_DISPATCH |=> $stable(phase_r))
    else $error("phase moved outside dispatch step");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(busy_r) && !busy_r)
    else $error("result appeared without a finished program");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= PC_END)
    else $error("step counter left the program");

endmodule

[tb/sv/rgb_status_animation_engine_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_status_animation_engine_unit_tb - frame-to-color checks for the engine
// Sends frame requests, predicts each RGB request from a local copy of the
// phase and the registers, and checks the colors in order under random
// stalls on both sides, register sweeps and a long output hold-off.
// ----------------------------------------------------------------------------
module rgb_status_animation_engine_unit_tb;
  import rsae_pkg::*;

  // Arithmetic constants of the animation curves
  localparam int unsigned LEVEL_MAX    = 255;
  localparam int unsigned HALF_PERIOD  = 32768;
  localparam int unsigned PHASE_TOP    = 65535;
  localparam int unsigned BEAT_SEG_LEN = 8192;

  // Register indexes past the last register; writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Leave margin after the last color before touching registers
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  typedef struct packed {
    logic [3:0] status_code;
    logic [7:0] spark_draw;
    logic [6:0] chance_draw;
    logic [5:0] glow_draw;
  } frame_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [23:0] cfg_data;

  rsae_in_if  frame_ch();
  rsae_out_if color_ch();

  rgb_status_animation_engine_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (frame_ch),
    .out_ch   (color_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the engine state: animation phase and register file
  logic [15:0] phase_model;
  logic [23:0] heartbeat_rgb;
  logic [23:0] breathe_rgb;
  logic [23:0] sparkle_rgb;
  logic [23:0] blend_from_rgb;
  logic [23:0] blend_to_rgb;
  logic [7:0]  peak_level;

  color_t      pending_colors[$];   // predicted colors, oldest first
  int unsigned error_count  = 0;
  int unsigned stall_count  = 0;
  int unsigned src_gap_pct  = 25;   // chance in percent the sender idles
  int unsigned snk_gap_pct  = 58;   // chance in percent the receiver stalls
  int unsigned holdoff_req  = 0;    // receiver hold-off, picked up by the sink

  // --------------------------------------------------------------------------
  // Color prediction
  // --------------------------------------------------------------------------

  // Scale each lane of a packed RRGGBB color by lvl/255, truncating.
  function automatic color_t shade(logic [23:0] rgb, int unsigned lvl);
    color_t c;
    c.red   = 8'((rgb[23:16] * lvl) / LEVEL_MAX);
    c.green = 8'((rgb[15:8]  * lvl) / LEVEL_MAX);
    c.blue  = 8'((rgb[7:0]   * lvl) / LEVEL_MAX);
    return c;
  endfunction

  // Triangle 0..254..0 over one phase turn.
  function automatic int unsigned tri_level(logic [15:0] ph);
    int unsigned p;
    p = ph;
    if (p < HALF_PERIOD) return (p * LEVEL_MAX) / HALF_PERIOD;
    return ((PHASE_TOP - p) * LEVEL_MAX) / HALF_PERIOD;
  endfunction

  // Move from s toward e by t/255; the step truncates, so a falling lane rounds up.
  function automatic logic [7:0] blend_lane(int unsigned s, int unsigned e,
                                            int unsigned t);
    if (e >= s) return 8'(s + ((e - s) * t) / LEVEL_MAX);
    return 8'(s - ((s - e) * t) / LEVEL_MAX);
  endfunction

  // Advance the phase for one frame and return the color it should give.
  function automatic color_t predict_color(frame_t f);
    int unsigned lvl;
    int unsigned base;
    int unsigned t;
    logic [2:0]  seg;
    color_t      c;
    c = '0;
    case (f.status_code)
      ST_HEARTBEAT: begin
        phase_model = phase_model + STEP_HEARTBEAT;
        seg = phase_model[15:13];
        lvl = (int'(phase_model[12:0]) * LEVEL_MAX) / BEAT_SEG_LEN;
        // two beats: rise/fall in segments 0..3, dark for the rest
        if (seg < 3'd4) begin
          if (seg[0]) lvl = LEVEL_MAX - lvl;
        end else begin
          lvl = 0;
        end
        c = shade(heartbeat_rgb, (lvl * peak_level) / LEVEL_MAX);
      end
      ST_BREATHE: begin
        phase_model = phase_model + STEP_BREATHE;
        lvl = tri_level(phase_model);
        lvl = (lvl * lvl) / LEVEL_MAX;
        c = shade(breathe_rgb, (lvl * peak_level) / LEVEL_MAX);
      end
      ST_SPARKLE: begin
        phase_model = phase_model + STEP_SPARKLE;
        base = peak_level / 3;
        if (f.chance_draw < CHANCE_BRIGHT) begin
          lvl = (f.spark_draw > base) ? int'(f.spark_draw) : base;
        end else begin
          lvl = base + f.glow_draw;
        end
        if (lvl > peak_level) lvl = peak_level;
        c = shade(sparkle_rgb, lvl);
      end
      ST_BLEND: begin
        phase_model = phase_model + STEP_BLEND;
        t = tri_level(phase_model);
        c = shade({blend_lane(blend_from_rgb[23:16], blend_to_rgb[23:16], t),
                   blend_lane(blend_from_rgb[15:8],  blend_to_rgb[15:8],  t),
                   blend_lane(blend_from_rgb[7:0],   blend_to_rgb[7:0],   t)},
                  peak_level);
      end
      default: c = '0;  // every other code is black, phase untouched
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard and watchdog. Input and output are sampled at the same edge,
  // so the prediction is queued before any color can be checked against it.
  // --------------------------------------------------------------------------
  task automatic check_lane(string lane, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, lane, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    frame_t f;
    color_t want;
    bit     moved;
    moved = 1'b0;
    if (rst_n) begin
      if (frame_ch.valid && frame_ch.ready) begin
        f.status_code = frame_ch.status_code;
        f.spark_draw  = frame_ch.spark_draw;
        f.chance_draw = frame_ch.chance_draw;
        f.glow_draw   = frame_ch.glow_draw;
        pending_colors.push_back(predict_color(f));
        moved = 1'b1;
      end
      if (color_ch.valid && color_ch.ready) begin
        moved = 1'b1;
        if (pending_colors.size() == 0) begin
          error_count++;
          $display("%0t: color request with none expected: actual %0d %0d %0d",
                   $time, color_ch.red_level, color_ch.green_level,
                   color_ch.blue_level);
        end else begin
          want = pending_colors.pop_front();
          check_lane("red_level",   want.red,   color_ch.red_level);
          check_lane("green_level", want.green, color_ch.green_level);
          check_lane("blue_level",  want.blue,  color_ch.blue_level);
        end
      end
    end
    if (moved) stall_count = 0;
    else stall_count++;
    if (stall_count >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
      $display("rgb_status_animation_engine_unit test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Color receiver: random stalls, plus a long hold-off on demand so the
  // output register fills and the engine backs up into the frame channel.
  // --------------------------------------------------------------------------
  initial begin : color_sink
    int unsigned hold;
    color_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req != 0) begin
        hold = holdoff_req;
        holdoff_req = 0;
        color_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      color_ch.ready <= ($urandom_range(99) >= snk_gap_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Frame sender and register access. All tasks are entered right after a
  // rising edge and return right after one.
  // --------------------------------------------------------------------------
  function automatic frame_t make_frame(logic [3:0] status, logic [7:0] spark,
                                        logic [6:0] chance, logic [5:0] glow);
    frame_t f;
    f.status_code = status;
    f.spark_draw  = spark;
    f.chance_draw = chance;
    f.glow_draw   = glow;
    return f;
  endfunction

  function automatic frame_t random_frame(logic [3:0] status);
    logic [6:0] chance;
    // bias toward the bright-sparkle window; now and then past 99
    case ($urandom_range(7))
      0, 1:    chance = 7'($urandom_range(14));
      2:       chance = 7'($urandom_range(127, 100));
      default: chance = 7'($urandom_range(99));
    endcase
    return make_frame(status, 8'($urandom_range(255)), chance,
                      6'($urandom_range(63)));
  endfunction

  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < src_gap_pct) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk);
    end
    frame_ch.valid       <= 1'b1;
    frame_ch.status_code <= f.status_code;
    frame_ch.spark_draw  <= f.spark_draw;
    frame_ch.chance_draw <= f.chance_draw;
    frame_ch.glow_draw   <= f.glow_draw;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
  endtask

  // Runs of one status sweep the phase through whole curves; short runs
  // and stray codes mix the animations.
  task automatic play_frames(int unsigned count);
    logic [3:0]  status;
    int unsigned run;
    while (count > 0) begin
      case ($urandom_range(9))
        0, 1, 2: status = ST_HEARTBEAT;
        3, 4:    status = ST_BREATHE;
        5, 6:    status = ST_SPARKLE;
        7, 8:    status = ST_BLEND;
        default: status = 4'($urandom_range(15));
      endcase
      run = $urandom_range(40, 1);
      if (run > count) run = count;
      count -= run;
      repeat (run) send_frame(random_frame(status));
    end
  endtask

  // Drop valid, wait until every color is back and the engine has settled.
  // One edge first, so the scoreboard has queued the last accepted frame.
  task automatic wait_idle();
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_HEARTBEAT:   heartbeat_rgb  = value;
      REG_BREATHE:     breathe_rgb    = value;
      REG_SPARKLE:     sparkle_rgb    = value;
      REG_BLEND_START: blend_from_rgb = value;
      REG_BLEND_END:   blend_to_rgb   = value;
      REG_PEAK:        peak_level     = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_registers(logic [23:0] hb, logic [23:0] br, logic [23:0] sp,
                                logic [23:0] from_rgb, logic [23:0] to_rgb,
                                logic [23:0] peak);
    write_reg(REG_HEARTBEAT,   hb);
    write_reg(REG_BREATHE,     br);
    write_reg(REG_SPARKLE,     sp);
    write_reg(REG_BLEND_START, from_rgb);
    write_reg(REG_BLEND_END,   to_rgb);
    write_reg(REG_PEAK,        peak);
  endtask

  function automatic logic [23:0] random_rgb();
    case ($urandom_range(7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Peak rides in the low byte; upper data bits are junk and must not matter.
  function automatic logic [23:0] random_peak();
    logic [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(7))
      0:       v[7:0] = 8'd255;
      1:       v[7:0] = 8'd0;
      2:       v[7:0] = 8'($urandom_range(3));
      default: ;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers: every status code once, then the sparkle draw corners.
  task automatic test_directed_frames();
    for (int code = 0; code < 16; code++) begin
      send_frame(make_frame(4'(code), 8'd200, 7'd50, 6'd10));
    end
    // spark above the glow base, at the bright edge of the chance window
    send_frame(make_frame(ST_SPARKLE, 8'd255, 7'd0,   6'd0));
    // spark below base: base wins
    send_frame(make_frame(ST_SPARKLE, 8'd0,   7'd14,  6'd63));
    // just out of the bright window: base plus glow
    send_frame(make_frame(ST_SPARKLE, 8'd255, 7'd15,  6'd63));
    // chance past its range counts as no bright sparkle
    send_frame(make_frame(ST_SPARKLE, 8'd170, 7'd127, 6'd0));
    send_frame(make_frame(ST_SPARKLE, 8'd85,  7'd99,  6'd42));
    wait_idle();
  endtask

  // Register corners: full white at full peak, all black at zero peak,
  // a blend with lanes going both ways, tiny peaks, dropped spare indexes.
  task automatic test_register_extremes();
    load_registers(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   24'h0000FF);
    play_frames(60);
    wait_idle();

    load_registers(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
                   24'h000000);
    play_frames(30);
    wait_idle();

    // red and blue fall, green rises across the blend
    load_registers(random_rgb(), random_rgb(), random_rgb(), 24'hFF20F0,
                   24'h00FF0F, 24'hFFFFFF);
    repeat (170) send_frame(random_frame(ST_BLEND));
    wait_idle();

    load_registers(random_rgb(), random_rgb(), random_rgb(), random_rgb(),
                   random_rgb(), 24'h000001);
    write_reg(REG_SPARE_LO, 24'($urandom));
    write_reg(REG_SPARE_HI, 24'($urandom));
    play_frames(40);
    wait_idle();
  endtask

  // Bulk traffic across the three idling patterns, new registers for each.
  task automatic test_random_traffic();
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          src_gap_pct = 25;
          snk_gap_pct = 58;
        end
        1: begin
          src_gap_pct = 58;
          snk_gap_pct = 25;
        end
        default: begin
          src_gap_pct = 0;
          snk_gap_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 3; chunk++) begin
        load_registers(random_rgb(), random_rgb(), random_rgb(), random_rgb(),
                       random_rgb(), random_peak());
        play_frames(170);
        wait_idle();
      end
    end
  endtask

  // Receiver holds off while frames keep coming: the engine fills and the
  // frame channel must stall without losing or reordering anything.
  task automatic test_output_holdoff();
    src_gap_pct = 0;
    snk_gap_pct = 0;
    holdoff_req = HOLDOFF_CYCLES;
    play_frames(60);
    wait_idle();
  endtask

  initial begin : main_seq
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_HEARTBEAT;
    cfg_data             <= '0;
    frame_ch.valid       <= 1'b0;
    frame_ch.status_code <= '0;
    frame_ch.spark_draw  <= '0;
    frame_ch.chance_draw <= '0;
    frame_ch.glow_draw   <= '0;

    phase_model    = '0;
    heartbeat_rgb  = RST_HEARTBEAT;
    breathe_rgb    = RST_BREATHE;
    sparkle_rgb    = RST_SPARKLE;
    blend_from_rgb = RST_BLEND_START;
    blend_to_rgb   = RST_BLEND_END;
    peak_level     = RST_PEAK;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_register_extremes();
    test_random_traffic();
    test_output_holdoff();

    if (error_count == 0) begin
      $display("rgb_status_animation_engine_unit test passed");
    end else begin
      $display("rgb_status_animation_engine_unit test failed");
    end
    $finish;
  end

endmodule
